[rtl/core/signed_radix_to_text_core_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the signed radix to text core
// Shared property wrappers for the concurrent assertions of the core.
// ----------------------------------------------------------------------------
`ifndef SIGNED_RADIX_TO_TEXT_CORE_MACROS_SVH
`define SIGNED_RADIX_TO_TEXT_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SRTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srtt assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SRTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srtt assertion failed");

`endif

[rtl/core/srtt_pkg.sv]
// ----------------------------------------------------------------------------
// srtt_pkg
// Types and constants shared by the signed radix to text core.
// ----------------------------------------------------------------------------
package srtt_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_BASE        = 16;
    localparam int RADIX_W         = 5;
    localparam int DIGIT_W         = 4;
    localparam int CHAR_W          = 8;
    localparam int SYMBOLS_W       = 64;
    localparam int CFG_INDEX_W     = 2;
    localparam int CFG_DATA_W      = 64;
    localparam int STEP_BITS       = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_INDEX_W-1:0] CFG_BASE_SIZE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0]   BASE_SIZE_RST    = 5'd10;
    localparam logic [SYMBOLS_W-1:0] SYMBOLS_LOW_RST  = 64'h3736_3534_3332_3130;
    localparam logic [SYMBOLS_W-1:0] SYMBOLS_HIGH_RST = 64'h0000_0000_0000_3938;

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_SIGN,
        ST_FETCH,
        ST_PUT
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_flags;

endpackage

[rtl/core/srtt_front.sv]
// ----------------------------------------------------------------------------
// srtt_front
// Accepts input transactions and splits each value into sign and magnitude.
// ----------------------------------------------------------------------------
module srtt_front
    import srtt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    input  t_fifo_flags                   i_flags,
    output logic                          o_push,
    output logic                          o_neg,
    output logic [VALUE_WIDTH-1:0]        o_mag
);

    logic                   r_valid;
    logic                   r_neg;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [VALUE_WIDTH-1:0] w_raw;
    logic                   w_neg;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_load;

    assign w_raw  = i_value;
    assign w_neg  = w_raw[VALUE_WIDTH-1];
    assign w_mag  = w_neg ? (~w_raw + 1'b1) : w_raw;
    assign o_push = r_valid && !i_flags.full;
    assign w_load = !r_valid || o_push;
    assign o_in_stall = !w_load;
    assign o_neg  = r_neg;
    assign o_mag  = r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_neg <= w_neg;
            r_mag <= w_mag;
        end
    end

endmodule

[rtl/core/srtt_queue.sv]
// ----------------------------------------------------------------------------
// srtt_queue
// Short FIFO between the classifying front and the converting back.
// ----------------------------------------------------------------------------
module srtt_queue
    import srtt_pkg::*;
#(
    parameter int DATA_W = VALUE_WIDTH_DEF + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output t_fifo_flags       o_flags
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [DATA_W-1:0] r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;
    logic [CNT_W-1:0]  n_count;

    assign o_flags.full  = (r_count == CNT_FULL);
    assign o_flags.empty = (r_count == '0);
    assign o_data        = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[rtl/core/srtt_back.sv]
// ----------------------------------------------------------------------------
// srtt_back
// Divides the magnitude into digits, stores them and emits the characters.
// ----------------------------------------------------------------------------
module srtt_back
    import srtt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_fifo_flags            i_flags,
    output logic                   o_pop,
    input  logic                   i_neg,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    input  logic [RADIX_W-1:0]     i_base_size,
    input  logic [SYMBOLS_W-1:0]   i_symbols_low,
    input  logic [SYMBOLS_W-1:0]   i_symbols_high,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [CHAR_W-1:0]      o_character,
    output logic                   o_last
);

    localparam int STEPS      = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int QW         = STEPS * STEP_BITS;
    localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int ADDR_W     = $clog2(VALUE_WIDTH);
    localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);
    localparam logic [STEP_CNT_W-1:0] LAST_STEP = STEP_CNT_W'(STEPS - 1);

    t_back_state             r_state;
    t_back_state             n_state;
    logic                    r_neg;
    logic                    n_neg;
    logic [QW-1:0]           r_quo;
    logic [QW-1:0]           n_quo;
    logic [DIGIT_W-1:0]      r_rem;
    logic [DIGIT_W-1:0]      n_rem;
    logic [STEP_CNT_W-1:0]   r_step;
    logic [STEP_CNT_W-1:0]   n_step;
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;
    logic                    r_out_valid;
    logic                    n_out_valid;
    logic [CHAR_W-1:0]       r_out_char;
    logic [CHAR_W-1:0]       n_out_char;
    logic                    r_out_last;
    logic                    n_out_last;
    logic [DIGIT_W-1:0]      r_rd_digit;
    logic [DIGIT_W-1:0]      r_digit_mem [VALUE_WIDTH];

    logic [RADIX_W-1:0]      w_radix;
    logic [QW-1:0]           w_quo;
    logic [DIGIT_W-1:0]      w_rem;
    logic [RADIX_W-1:0]      w_trial;
    logic                    w_out_free;
    logic                    w_mem_we;
    logic [ADDR_W-1:0]       w_wr_addr;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic [CNT_W-1:0]        w_count_dec;
    logic [2*SYMBOLS_W-1:0]  w_symbols;
    logic [CHAR_W-1:0]       w_symbol;

    assign w_radix = (i_base_size < RADIX_W'(2)) ? RADIX_W'(2) :
                     (i_base_size > RADIX_W'(MAX_BASE)) ? RADIX_W'(MAX_BASE) : i_base_size;

    // Restoring division of the running quotient, several bits per cycle.
    always_comb begin
        w_rem   = r_rem;
        w_quo   = r_quo;
        w_trial = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            w_trial = {w_rem, w_quo[QW-1]};
            w_quo   = {w_quo[QW-2:0], 1'b0};
            if (w_trial >= w_radix) begin
                w_trial  = w_trial - w_radix;
                w_quo[0] = 1'b1;
            end
            w_rem = w_trial[DIGIT_W-1:0];
        end
    end

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_wr_addr   = r_count[ADDR_W-1:0];
    assign w_count_dec = r_count - 1'b1;
    assign w_rd_addr   = w_count_dec[ADDR_W-1:0];
    assign w_symbols   = {i_symbols_high, i_symbols_low};
    assign w_symbol    = w_symbols[{r_rd_digit, 3'b000} +: CHAR_W];

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_step      = r_step;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        o_pop       = 1'b0;
        w_mem_we    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_flags.empty) begin
                    o_pop   = 1'b1;
                    n_neg   = i_neg;
                    n_quo   = QW'(i_mag);
                    n_rem   = '0;
                    n_step  = '0;
                    n_count = '0;
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                n_quo  = w_quo;
                n_rem  = w_rem;
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    w_mem_we = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_step   = '0;
                    n_rem    = '0;
                    if (w_quo == '0) begin
                        n_state = r_neg ? ST_SIGN : ST_FETCH;
                    end
                end
            end
            ST_SIGN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = MINUS_CHAR;
                    n_out_last  = 1'b0;
                    n_state     = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_PUT;
            end
            ST_PUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_char  = w_symbol;
                    n_out_last  = (r_count == CNT_W'(1));
                    n_count     = w_count_dec;
                    n_state     = (r_count == CNT_W'(1)) ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_neg      <= n_neg;
        r_quo      <= n_quo;
        r_rem      <= n_rem;
        r_step     <= n_step;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_digit_mem[w_wr_addr] <= w_rem;
        end
        r_rd_digit <= r_digit_mem[w_rd_addr];
    end

    assign o_out_valid = r_out_valid;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

endmodule

[rtl/core/signed_radix_to_text_core.sv]
// ----------------------------------------------------------------------------
// signed_radix_to_text_core: signed integer to text in a radix from 2 to 16
// Path: front register and queue, then the back divides the magnitude digit by digit
// in the shared divide step, emits a sign if negative, then fetches and puts each character.
// The back converts one value at a time; the front and queue hold further values meanwhile.
// Synchronous active-low reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
`include "signed_radix_to_text_core_macros.svh"

module signed_radix_to_text_core
    import srtt_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [CHAR_W-1:0]             o_character,
    output logic                          o_last,
    input  logic                          i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data
);

    logic [RADIX_W-1:0]     r_base_size;
    logic [SYMBOLS_W-1:0]   r_symbols_low;
    logic [SYMBOLS_W-1:0]   r_symbols_high;

    t_fifo_flags            w_q_flags;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_front_neg;
    logic [VALUE_WIDTH-1:0] w_front_mag;
    logic [VALUE_WIDTH:0]   w_q_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_size    <= BASE_SIZE_RST;
            r_symbols_low  <= SYMBOLS_LOW_RST;
            r_symbols_high <= SYMBOLS_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BASE_SIZE: begin
                    r_base_size <= i_cfg_data[RADIX_W-1:0];
                end
                CFG_SYMBOLS_LOW: begin
                    r_symbols_low <= i_cfg_data[SYMBOLS_W-1:0];
                end
                CFG_SYMBOLS_HIGH: begin
                    r_symbols_high <= i_cfg_data[SYMBOLS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    srtt_front #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .i_flags    (w_q_flags),
        .o_push     (w_push),
        .o_neg      (w_front_neg),
        .o_mag      (w_front_mag)
    );

    srtt_queue #(
        .DATA_W(VALUE_WIDTH + 1)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_neg, w_front_mag}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_flags (w_q_flags)
    );

    srtt_back #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_flags        (w_q_flags),
        .o_pop          (w_pop),
        .i_neg          (w_q_out[VALUE_WIDTH]),
        .i_mag          (w_q_out[VALUE_WIDTH-1:0]),
        .i_base_size    (r_base_size),
        .i_symbols_low  (r_symbols_low),
        .i_symbols_high (r_symbols_high),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_character    (o_character),
        .o_last         (o_last)
    );

    `SRTT_ASSERT_IMPL(a_push_not_full, i_clk, i_rst_n, w_push, !w_q_flags.full)
    `SRTT_ASSERT_IMPL(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_q_flags.empty)
    `SRTT_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push && !w_pop, !w_q_flags.empty)

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for the signed radix to text core
// Sends signed values under several radix and symbol table settings and
// predicts the text that each one produces, one character per transaction.
// Each character and last flag is checked in order against the prediction.
// Random idle cycles on both channels, a long output hold-off and random
// register settings exercise the handshakes and the radix clamping.
// ----------------------------------------------------------------------------
module tb_top;
    import srtt_pkg::*;

    localparam int VW = VALUE_WIDTH_DEF;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT    = 5000;
    localparam int SETTLE_CYCLES     = 40;
    localparam int HOLD_CYCLES       = 400;
    localparam int ITEMS_PER_SETTING = 34;
    localparam int MAX_PRINTED       = 50;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              is_last;
    } t_text_char;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_in_valid  = 1'b0;
    logic                    o_in_stall;
    logic signed [VW-1:0]    i_value     = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [CHAR_W-1:0]       o_character;
    logic                    o_last;
    logic                    i_cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;

    logic [RADIX_W-1:0]      radix_cfg   = BASE_SIZE_RST;
    logic [2*SYMBOLS_W-1:0]  symbols_cfg = {SYMBOLS_HIGH_RST, SYMBOLS_LOW_RST};

    t_text_char pending_chars[$];
    int         mismatch_count = 0;
    int         send_idle_pct  = 16;
    int         recv_idle_pct  = 78;
    int         hold_left      = 0;
    logic       hold_start     = 1'b0;
    logic       hold_seen      = 1'b0;
    int         idle_cycles    = 0;

    signed_radix_to_text_core #(
        .VALUE_WIDTH(VW)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_value    (i_value),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_character(o_character),
        .o_last     (o_last),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void queue_text_of(input logic [VW-1:0] value);
        logic [VW-1:0]      magnitude;
        logic [RADIX_W-1:0] radix;
        logic [DIGIT_W-1:0] digits[$];
        int                 d;
        radix = radix_cfg;
        if (radix < RADIX_W'(2)) begin
            radix = RADIX_W'(2);
        end
        if (radix > RADIX_W'(MAX_BASE)) begin
            radix = RADIX_W'(MAX_BASE);
        end
        magnitude = value[VW-1] ? ~value + 1'b1 : value;
        do begin
            digits.push_back(DIGIT_W'(magnitude % radix));
            magnitude = magnitude / radix;
        end while (magnitude != 0);
        if (value[VW-1]) begin
            pending_chars.push_back('{MINUS_CHAR, 1'b0});
        end
        for (int k = digits.size() - 1; k >= 0; k--) begin
            d = digits[k];
            pending_chars.push_back('{symbols_cfg[CHAR_W*d +: CHAR_W], k == 0});
        end
    endfunction

    function automatic logic [VW-1:0] random_value();
        logic [VW-1:0] v;
        case ($urandom_range(0, 5))
            0: begin
                v = $urandom_range(0, 40) - 20;
            end
            1: begin
                v = VW'(1) << $urandom_range(0, VW - 1);
                v = v - $urandom_range(0, 1);
                if ($urandom_range(0, 1)) begin
                    v = ~v + 1'b1;
                end
            end
            2: begin
                v = $urandom_range(0, 1) ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
            end
            default: begin
                v = $urandom;
            end
        endcase
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
                                   input logic [CHAR_W-1:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED) begin
            $display("ERROR at %0t: %s is %h, want %h", $time, what, got, want);
        end
    endtask

    task automatic send_value(input logic [VW-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        queue_text_of(value);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (index)
            CFG_BASE_SIZE:    radix_cfg = data[RADIX_W-1:0];
            CFG_SYMBOLS_LOW:  symbols_cfg[SYMBOLS_W-1:0] = data;
            CFG_SYMBOLS_HIGH: symbols_cfg[2*SYMBOLS_W-1:SYMBOLS_W] = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic test_reset_defaults();
        send_value(0);
        send_value(7);
        send_value(-1);
        send_value({1'b0, {(VW-1){1'b1}}});
        send_value({1'b1, {(VW-1){1'b0}}});
        send_value(1000000000);
        settle();
    endtask

    task automatic test_radix_clamping();
        write_cfg(CFG_BASE_SIZE, 0);
        send_value({1'b1, {(VW-1){1'b0}}});
        send_value(5);
        settle();
        write_cfg(CFG_BASE_SIZE, 1);
        send_value(255);
        settle();
        write_cfg(CFG_BASE_SIZE, '1);
        send_value({1'b0, {(VW-1){1'b1}}});
        settle();
        write_cfg(CFG_BASE_SIZE, 17);
        send_value(-1);
        settle();
        write_cfg(CFG_BASE_SIZE, MAX_BASE);
        send_value(32'hFEDC_BA98);
        settle();
        write_cfg(CFG_UNUSED, {$urandom, $urandom});
        send_value(32'h89AB_CDEF);
        settle();
    endtask

    task automatic test_symbol_tables();
        write_cfg(CFG_SYMBOLS_LOW, '1);
        write_cfg(CFG_SYMBOLS_HIGH, '0);
        send_value(32'h0123_4567);
        send_value(32'h79AB_CDEF);
        settle();
        write_cfg(CFG_SYMBOLS_LOW, '0);
        write_cfg(CFG_SYMBOLS_HIGH, '1);
        send_value(32'h0123_4567);
        send_value(32'h79AB_CDEF);
        settle();
    endtask

    task automatic test_back_pressure();
        send_idle_pct = 0;
        write_cfg(CFG_BASE_SIZE, 2);
        hold_start = 1'b1;
        repeat (16) send_value(random_value());
        settle();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct);
        logic [CFG_DATA_W-1:0] data;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int s = 0; s < 4; s++) begin
            data = {$urandom, $urandom};
            data[RADIX_W-1:0] = (s == 0) ? RADIX_W'(2) :
                                (s == 1) ? RADIX_W'(MAX_BASE) : RADIX_W'($urandom_range(0, 31));
            write_cfg(CFG_BASE_SIZE, data);
            write_cfg(CFG_SYMBOLS_LOW, {$urandom, $urandom});
            write_cfg(CFG_SYMBOLS_HIGH, {$urandom, $urandom});
            repeat (ITEMS_PER_SETTING) send_value(random_value());
            settle();
        end
    endtask

    always @(posedge i_clk) begin
        t_text_char want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("unexpected character", o_character, '0);
            end else begin
                want = pending_chars.pop_front();
                if (o_character !== want.character) begin
                    report_mismatch("character", o_character, want.character);
                end
                if (o_last !== want.is_last) begin
                    report_mismatch("last flag", CHAR_W'(o_last), CHAR_W'(want.is_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_start && !hold_seen) begin
            hold_seen   <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_radix_clamping();
        test_symbol_tables();
        test_random_phase(16, 78);
        test_random_phase(78, 16);
        test_back_pressure();
        test_random_phase(0, 0);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
